[rtl/lcdst_pkg.sv]
// ----------------------------------------------------------------------------
// lcdst_pkg: shared types and constants of the LCD scanline timing controller
// Payload structs, register indexes, mode codes and timing defaults.
// ----------------------------------------------------------------------------
package lcdst_pkg;

   // Field widths fixed by the interface definition.
   localparam int unsigned CYCLE_W = 10;
   localparam int unsigned LINE_W  = 8;
   localparam int unsigned TICK_W  = 8;
   localparam int unsigned CSR_W   = 8;
   localparam int unsigned CSR_IDX_W = 3;

   // Timing defaults for the top-level parameters.
   localparam int unsigned DEF_CYCLES_PER_LINE = 456;
   localparam int unsigned DEF_VISIBLE_LINES   = 144;
   localparam int unsigned DEF_LAST_LINE       = 153;

   // Fixed mode boundaries within a line.
   localparam logic [CYCLE_W-1:0] OAM_END_CYCLE       = 10'd80;
   localparam logic [CYCLE_W-1:0] TRANSFER_LAST_CYCLE = 10'd252;

   // The window counts lines only while its position is left of this limit.
   localparam int unsigned SCREEN_COLUMNS  = 160;
   localparam int unsigned WINDOW_X_OFFSET = 7;
   localparam logic [LINE_W-1:0] WINDOW_X_LIMIT =
      LINE_W'(SCREEN_COLUMNS - 1 + WINDOW_X_OFFSET);

   // Register indexes on the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_LCD_ENABLE         = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STATUS_INT_ENABLES = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COMPARE_LINE       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_X           = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_Y           = 3'd4;

   // Bit positions within status_int_enables.
   localparam int unsigned SIE_HBLANK  = 0;
   localparam int unsigned SIE_VBLANK  = 1;
   localparam int unsigned SIE_OAM     = 2;
   localparam int unsigned SIE_COMPARE = 3;

   typedef enum logic [1:0] {
      MODE_HBLANK   = 2'd0,
      MODE_VBLANK   = 2'd1,
      MODE_OAM      = 2'd2,
      MODE_TRANSFER = 2'd3
   } mode_type;

   typedef struct packed {
      logic              lcd_enable;
      logic [3:0]        status_int_enables;
      logic [LINE_W-1:0] compare_line;
      logic [LINE_W-1:0] win_xpos;
      logic [LINE_W-1:0] win_ypos;
   } cfg_type;

   typedef struct packed {
      logic [TICK_W-1:0] tick_count;
   } req_type;

   typedef struct packed {
      logic [LINE_W-1:0] line;
      mode_type          mode;
      logic              coincidence;
      logic [LINE_W-1:0] window_line;
      logic              vblank_irq;
      logic              status_irq;
      logic              line_end;
   } rsp_type;

endpackage

[rtl/lcdst_chan_if.sv]
// ----------------------------------------------------------------------------
// lcdst_chan_if: valid/ready channel
// Carries one payload per handshake; the payload type is set per instance.
// ----------------------------------------------------------------------------
interface lcdst_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

[rtl/lcdst_csr.sv]
// ----------------------------------------------------------------------------
// lcdst_csr: configuration registers
// Write-only register file written through the index/data port.
// ----------------------------------------------------------------------------
module lcdst_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [lcdst_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [lcdst_pkg::CSR_W-1:0]      csr_wdata,
   output lcdst_pkg::cfg_type               cfg
);
   import lcdst_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_LCD_ENABLE:         cfg_in.lcd_enable         = csr_wdata[0];
            CSR_STATUS_INT_ENABLES: cfg_in.status_int_enables = csr_wdata[3:0];
            CSR_COMPARE_LINE:       cfg_in.compare_line       = csr_wdata;
            CSR_WINDOW_X:           cfg_in.win_xpos           = csr_wdata;
            CSR_WINDOW_Y:           cfg_in.win_ypos           = csr_wdata;
            default:                cfg_in                    = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[rtl/lcdst_seq.sv]
// ----------------------------------------------------------------------------
// lcdst_seq: line timing state and single-step update
// Holds the line, cycle, window and mode state and computes one step's result.
// ----------------------------------------------------------------------------
module lcdst_seq #(
   parameter int unsigned CYCLES_PER_LINE = lcdst_pkg::DEF_CYCLES_PER_LINE,
   parameter int unsigned VISIBLE_LINES   = lcdst_pkg::DEF_VISIBLE_LINES,
   parameter int unsigned LAST_LINE       = lcdst_pkg::DEF_LAST_LINE
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           step_en,
   input  logic [lcdst_pkg::TICK_W-1:0]   tick_count,
   input  lcdst_pkg::cfg_type             cfg,
   output lcdst_pkg::rsp_type             result
);
   import lcdst_pkg::*;

   localparam logic [CYCLE_W-1:0] CPL       = CYCLE_W'(CYCLES_PER_LINE);
   localparam logic [LINE_W-1:0]  VIS       = LINE_W'(VISIBLE_LINES);
   localparam logic [LINE_W-1:0]  LAST      = LINE_W'(LAST_LINE);
   localparam logic [LINE_W:0]    WIN_Y_LIM = (LINE_W+1)'(VISIBLE_LINES - 1);

   logic [CYCLE_W-1:0] cycle_ff, cycle_in;
   logic [LINE_W-1:0]  line_ff, line_in;
   logic [LINE_W-1:0]  wline_ff, wline_in;
   mode_type           mode_ff, mode_in;
   logic               coin_ff, coin_in;
   logic               vblank_irq, status_irq, line_end;

   always_comb begin
      logic               irq_en;
      logic [CYCLE_W-1:0] sum;

      irq_en     = 1'b0;
      sum        = cycle_ff + CYCLE_W'(tick_count);
      cycle_in   = cycle_ff;
      line_in    = line_ff;
      wline_in   = wline_ff;
      coin_in    = coin_ff;
      vblank_irq = 1'b0;
      line_end   = 1'b0;

      // Mode follows the position as it stood before this step's clocks.
      priority if (line_ff >= VIS || !cfg.lcd_enable) begin
         mode_in = MODE_VBLANK;
         irq_en  = cfg.status_int_enables[SIE_VBLANK];
      end else if (cycle_ff < OAM_END_CYCLE) begin
         mode_in = MODE_OAM;
         irq_en  = cfg.status_int_enables[SIE_OAM];
      end else if (cycle_ff <= TRANSFER_LAST_CYCLE) begin
         mode_in = MODE_TRANSFER;
      end else begin
         mode_in = MODE_HBLANK;
         irq_en  = cfg.status_int_enables[SIE_HBLANK];
      end
      status_irq = (mode_in != mode_ff) && irq_en;

      if (!cfg.lcd_enable) begin
         cycle_in = '0;
         line_in  = '0;
         wline_in = '0;
      end else if (sum >= CPL) begin
         // Line finished: leftover clocks are dropped.
         cycle_in   = '0;
         line_end   = 1'b1;
         vblank_irq = (line_ff == VIS);
         if (line_ff == LAST) begin
            line_in  = '0;
            wline_in = '0;
         end else begin
            line_in = line_ff + 1'b1;
            if (cfg.win_xpos < WINDOW_X_LIMIT && {1'b0, cfg.win_ypos} < WIN_Y_LIM) begin
               wline_in = wline_ff + 1'b1;
            end
         end
         coin_in = (cfg.compare_line == line_in);
         if (coin_in && cfg.status_int_enables[SIE_COMPARE]) begin
            status_irq = 1'b1;
         end
      end else begin
         cycle_in = sum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cycle_ff <= '0;
         line_ff  <= '0;
         wline_ff <= '0;
         mode_ff  <= MODE_HBLANK;
         coin_ff  <= 1'b0;
      end else if (step_en) begin
         cycle_ff <= cycle_in;
         line_ff  <= line_in;
         wline_ff <= wline_in;
         mode_ff  <= mode_in;
         coin_ff  <= coin_in;
      end
   end

   always_comb begin
      result.line        = line_in;
      result.mode        = mode_in;
      result.coincidence = coin_in;
      result.window_line = wline_in;
      result.vblank_irq  = vblank_irq;
      result.status_irq  = status_irq;
      result.line_end    = line_end;
   end

endmodule

[rtl/lcd_scanline_timing_controller_core.sv]
// ----------------------------------------------------------------------------
// lcd_scanline_timing_controller_core: LCD status-mode and scanline sequencer
// Turns elapsed-clock requests into line, mode, window line and interrupts.
// ----------------------------------------------------------------------------
// Each request on req_if carries the number of clocks elapsed since the
// previous one and produces exactly one response on rsp_if with the line, the
// display mode, the coincidence flag, the window line and the vblank, status
// and line-end pulses of that step. The block takes one request per clock
// while rsp_if is ready: a request is captured in an input register, and
// once the result register is free or being emptied the sequencer updates
// its state in a single pass and loads the result register. Every request
// must see the line and cycle counters as its predecessor left them. The
// result register and the input register are separate stages, so a new
// request is taken while an earlier response still waits on rsp_if.ready.
// Configuration registers are written through csr_wr_en, csr_index and
// csr_wdata and should only change while no request is in flight.
// ----------------------------------------------------------------------------
module lcd_scanline_timing_controller_core #(
   parameter int unsigned CYCLES_PER_LINE = lcdst_pkg::DEF_CYCLES_PER_LINE,
   parameter int unsigned VISIBLE_LINES   = lcdst_pkg::DEF_VISIBLE_LINES,
   parameter int unsigned LAST_LINE       = lcdst_pkg::DEF_LAST_LINE
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic [lcdst_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [lcdst_pkg::CSR_W-1:0]     csr_wdata,
   lcdst_chan_if.sink                      req_if,
   lcdst_chan_if.source                    rsp_if
);
   import lcdst_pkg::*;

   cfg_type           cfg;
   rsp_type           step_result;

   // Input stage: one pending request.
   logic              in_valid_ff, in_valid_in;
   logic [TICK_W-1:0] tick_ff;

   // Result stage: one response waiting for the consumer.
   logic              out_valid_ff, out_valid_in;
   rsp_type           rsp_ff;

   logic              step_go;
   logic              req_take;

   // The step runs when a request is held and the result register is free
   // or being emptied in this same cycle.
   assign step_go  = in_valid_ff && (!out_valid_ff || rsp_if.ready);
   assign req_take = req_if.valid && req_if.ready;

   assign req_if.ready = !in_valid_ff || step_go;

   always_comb begin
      in_valid_in  = in_valid_ff;
      out_valid_in = out_valid_ff;
      if (step_go) begin
         in_valid_in = 1'b0;
      end
      if (req_take) begin
         in_valid_in = 1'b1;
      end
      if (out_valid_ff && rsp_if.ready) begin
         out_valid_in = 1'b0;
      end
      if (step_go) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         tick_ff <= req_if.payload.tick_count;
      end
      if (step_go) begin
         rsp_ff <= step_result;
      end
   end

   lcdst_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   lcdst_seq #(
      .CYCLES_PER_LINE (CYCLES_PER_LINE),
      .VISIBLE_LINES   (VISIBLE_LINES),
      .LAST_LINE       (LAST_LINE)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .step_en    (step_go),
      .tick_count (tick_ff),
      .cfg        (cfg),
      .result     (step_result)
   );

   assign rsp_if.valid   = out_valid_ff;
   assign rsp_if.payload = rsp_ff;

endmodule

[verif/lcd_scanline_timing_controller_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcd_scanline_timing_controller_core_tb: scanline sequencer regression
// Feeds elapsed-clock requests through several register settings, predicts
// every response with a cycle-accurate line/mode tracker and compares each
// response field by field, with random idling on both channels.
// ----------------------------------------------------------------------------
module lcd_scanline_timing_controller_core_tb;
   import lcdst_pkg::*;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0]     csr_wdata;

   lcdst_chan_if #(.payload_type(req_type)) req_if ();
   lcdst_chan_if #(.payload_type(rsp_type)) rsp_if ();

   lcd_scanline_timing_controller_core dut (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_if    (req_if),
      .rsp_if    (rsp_if)
   );

   always #6 clock = ~clock;

   // Shadow copy of the registers, updated as each write lands.
   cfg_type shadow_cfg = '0;

   // Tracked sequencer state; this mirrors what the block holds internally.
   logic [CYCLE_W-1:0] cyc_count = '0;
   logic [LINE_W-1:0]  cur_line  = '0;
   logic [LINE_W-1:0]  win_count = '0;
   mode_type           cur_mode  = MODE_HBLANK;
   logic               coin_flag = 1'b0;

   logic [TICK_W-1:0] tick_q[$];        // requests still to be offered
   rsp_type           line_status_q[$]; // predicted responses, oldest first
   int unsigned       queued_total   = 0;
   int unsigned       accepted_total = 0;
   int unsigned       responses_seen = 0;
   int unsigned       mismatches     = 0;

   // While set, neither side inserts idle cycles. The final phase runs calm.
   logic calm = 1'b0;

   // Advances the tracked state by one request and returns the response that
   // the block must produce for it. The mode is decided from the line and the
   // cycle count as they stood before the new clocks are added.
   function automatic rsp_type advance_scanline(input logic [TICK_W-1:0] ticks);
      rsp_type  r;
      mode_type next_mode;
      logic     irq_en;
      r = '0;
      if (cur_line >= DEF_VISIBLE_LINES || !shadow_cfg.lcd_enable) begin
         next_mode = MODE_VBLANK;
         irq_en    = shadow_cfg.status_int_enables[SIE_VBLANK];
      end else if (cyc_count < OAM_END_CYCLE) begin
         next_mode = MODE_OAM;
         irq_en    = shadow_cfg.status_int_enables[SIE_OAM];
      end else if (cyc_count <= TRANSFER_LAST_CYCLE) begin
         // Pixel transfer has no interrupt enable of its own.
         next_mode = MODE_TRANSFER;
         irq_en    = 1'b0;
      end else begin
         next_mode = MODE_HBLANK;
         irq_en    = shadow_cfg.status_int_enables[SIE_HBLANK];
      end
      if (next_mode != cur_mode) begin
         r.status_irq = irq_en;
         cur_mode     = next_mode;
      end

      if (!shadow_cfg.lcd_enable) begin
         // Display off holds the timing at zero but keeps the coincidence flag.
         cur_line  = '0;
         cyc_count = '0;
         win_count = '0;
      end else begin
         cyc_count = cyc_count + CYCLE_W'(ticks);
         if (cyc_count >= DEF_CYCLES_PER_LINE) begin
            // The clocks past the end of the line are dropped.
            cyc_count  = '0;
            r.line_end = 1'b1;
            if (cur_line == DEF_VISIBLE_LINES)
               r.vblank_irq = 1'b1;
            if (cur_line == DEF_LAST_LINE) begin
               cur_line  = '0;
               win_count = '0;
            end else begin
               cur_line = cur_line + 1'b1;
               if (shadow_cfg.win_xpos < WINDOW_X_LIMIT &&
                   shadow_cfg.win_ypos < DEF_VISIBLE_LINES - 1)
                  win_count = win_count + 1'b1;
            end
            coin_flag = (shadow_cfg.compare_line == cur_line);
            if (coin_flag && shadow_cfg.status_int_enables[SIE_COMPARE])
               r.status_irq = 1'b1;
         end
      end

      r.line        = cur_line;
      r.mode        = cur_mode;
      r.coincidence = coin_flag;
      r.window_line = win_count;
      return r;
   endfunction

   // Request driver: predicts each request as it is accepted, then offers the
   // next pending one, now and then after a burst of idle cycles.
   int unsigned gap_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            line_status_q.push_back(advance_scanline(req_if.payload.tick_count));
            accepted_total++;
         end
         if (!req_if.valid || req_if.ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_if.valid <= 1'b0;
            end else if (tick_q.size() > 0) begin
               req_if.valid              <= 1'b1;
               req_if.payload.tick_count <= tick_q.pop_front();
               if (!calm && $urandom_range(0, 5) == 0)
                  gap_left = $urandom_range(1, 13);
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   task automatic check_status(input rsp_type got);
      rsp_type want;
      responses_seen++;
      if (line_status_q.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("%0t: response with nothing pending: line=%0d mode=%0d", $realtime,
                     got.line, got.mode);
      end else begin
         want = line_status_q.pop_front();
         if (got.line !== want.line || got.mode !== want.mode ||
             got.coincidence !== want.coincidence || got.window_line !== want.window_line ||
             got.vblank_irq !== want.vblank_irq || got.status_irq !== want.status_irq ||
             got.line_end !== want.line_end) begin
            mismatches++;
            if (mismatches <= 10)
               $display({"%0t: response %0d mismatch (line mode coin wline vbl stat end)",
                         " expected %0d %0d %0b %0d %0b %0b %0b actual %0d %0d %0b %0d",
                         " %0b %0b %0b"}, $realtime, responses_seen,
                        want.line, want.mode, want.coincidence, want.window_line,
                        want.vblank_irq, want.status_irq, want.line_end,
                        got.line, got.mode, got.coincidence, got.window_line,
                        got.vblank_irq, got.status_irq, got.line_end);
         end
      end
   endtask

   // Response monitor: checks each accepted response and stalls the channel in
   // random bursts. Once, well into the run, it holds off for a long stretch
   // so that the block fills up and has to stall its request side.
   int unsigned hold_left       = 0;
   logic        long_stall_done = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready)
            check_status(rsp_if.payload);
         if (!long_stall_done && responses_seen >= 700) begin
            long_stall_done = 1'b1;
            hold_left       = 200;
         end else if (hold_left == 0 && !calm && $urandom_range(0, 7) == 0) begin
            hold_left = $urandom_range(1, 13);
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // The shadow copy follows each register write as it lands.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_W-1:0] data);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_LCD_ENABLE:         shadow_cfg.lcd_enable         = data[0];
         CSR_STATUS_INT_ENABLES: shadow_cfg.status_int_enables = data[3:0];
         CSR_COMPARE_LINE:       shadow_cfg.compare_line       = data;
         CSR_WINDOW_X:           shadow_cfg.win_xpos           = data;
         CSR_WINDOW_Y:           shadow_cfg.win_ypos           = data;
         default: ;
      endcase
   endtask

   task automatic apply_config(input logic en, input logic [3:0] sie,
                               input logic [7:0] cmp, input logic [7:0] wx,
                               input logic [7:0] wy);
      write_reg(CSR_LCD_ENABLE, CSR_W'(en));
      write_reg(CSR_STATUS_INT_ENABLES, CSR_W'(sie));
      write_reg(CSR_COMPARE_LINE, cmp);
      write_reg(CSR_WINDOW_X, wx);
      write_reg(CSR_WINDOW_Y, wy);
   endtask

   task automatic queue_tick(input logic [TICK_W-1:0] ticks);
      tick_q.push_back(ticks);
      queued_total++;
   endtask

   // Every request yields a response, so the block is idle once all requests
   // are accepted and answered; a short pause covers the input and result registers.
   task automatic wait_drained();
      while (accepted_total != queued_total || line_status_q.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Mostly large steps so that whole frames go by, with some small ones that
   // land near the mode boundaries inside a line.
   function automatic logic [TICK_W-1:0] pick_tick();
      int unsigned roll;
      roll = $urandom_range(0, 9);
      if (roll < 6)
         return TICK_W'($urandom_range(150, 255));
      else if (roll < 9)
         return TICK_W'($urandom);
      else
         return TICK_W'($urandom_range(0, 15));
   endfunction

   initial begin
      logic       en;
      logic [3:0] sie;
      logic [7:0] cmp;
      logic [7:0] wx;
      logic [7:0] wy;
      int         count;

      reset        = 1'b1;
      csr_wr_en    = 1'b0;
      csr_index    = '0;
      csr_wdata    = '0;
      req_if.valid = 1'b0;
      req_if.payload = '0;
      rsp_if.ready = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Display off: everything stays at zero and the mode reads vblank.
      apply_config(1'b0, 4'hF, 8'd0, 8'd0, 8'd0);
      queue_tick(8'd0);
      queue_tick(8'd255);
      queue_tick(8'd128);
      wait_drained();

      // Display on, walking one line across each mode boundary: the last OAM
      // cycle, the first and last transfer cycles, the first hblank cycle, an
      // exact line end, and a line end that drops excess clocks. The window
      // sits just inside both limits so the window line counts.
      apply_config(1'b1, 4'hF, 8'd2, 8'd165, 8'd142);
      queue_tick(8'd79);
      queue_tick(8'd1);
      queue_tick(8'd172);
      queue_tick(8'd1);
      queue_tick(8'd0);
      queue_tick(8'd203);
      queue_tick(8'd255);
      queue_tick(8'd255);
      queue_tick(8'd0);
      queue_tick(8'd0);
      queue_tick(8'd128);
      queue_tick(8'd128);
      queue_tick(8'd200);
      wait_drained();

      // Switching off again must clear the timing but keep the coincidence flag.
      write_reg(CSR_LCD_ENABLE, CSR_W'(1'b0));
      queue_tick(8'd5);
      queue_tick(8'd255);
      queue_tick(8'd0);
      wait_drained();

      // Random phases. Line state carries over between consecutive enabled phases,
      // so the runs go through vblank at line 144 and the wrap after line 153.
      for (int k = 0; k < 6; k++) begin
         en  = (k != 2);
         sie = 4'($urandom_range(0, 15));
         cmp = 8'($urandom_range(0, 153));
         wx  = 8'($urandom);
         wy  = 8'($urandom);
         case (k)
            0: begin sie = 4'hF; cmp = 8'd144; wx = 8'd166; wy = 8'd0;   end
            1: begin sie = 4'h0; cmp = 8'd0;   wx = 8'd0;   wy = 8'd143; end
            2: begin                           wx = 8'd255; wy = 8'd255; end
            3: begin             cmp = 8'd153; wx = 8'd165; wy = 8'd142; end
            4: begin             cmp = 8'd255;                           end
            default: ;
         endcase
         apply_config(en, sie, cmp, wx, wy);
         if (k == 5)
            calm <= 1'b1;
         count = (k == 2) ? 60 : 260;
         repeat (count) queue_tick(pick_tick());
         wait_drained();
      end

      repeat (8) @(posedge clock);
      if (mismatches == 0 && line_status_q.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   // Far beyond the slowest correct run.
   initial begin
      #5_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
